FILE: sv/lldq_pkg.sv
// Package for the linked list deque engine: payload structs, opcodes and defaults.
// Depends on nothing; used by linked_list_deque_engine.
`default_nettype none
package lldq_pkg;
  localparam int CAPACITY_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_DELETE     = 3'd4;
  localparam logic [2:0] OP_SEARCH     = 3'd5;
  localparam logic [2:0] OP_SWAP       = 3'd6;
  localparam logic [2:0] OP_UNUSED     = 3'd7;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] value_out;
    logic [6:0]         count_now;
    logic               refused_full;
  } rsp_t;
endpackage
`default_nettype wire

FILE: sv/linked_list_deque_engine.sv
// Linked list deque engine: a doubly linked chain of values in one node memory.
// A push onto an empty list goes straight to S_OUT; other pushes link the old end in S_PUSH.
// Pops and deletes unlink in S_UNL1, then S_UNL2 unless the node was the tail or the only one.
// Search, delete and swap walk from the front, one node read a cycle; swap walks twice.
// One operation at a time: the next input transfer is taken only after the result transfer
// has cleared out_valid. Reset clears the used map, count, head and tail.
`default_nettype none
module linked_list_deque_engine #(
  parameter int CAPACITY   = lldq_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = lldq_pkg::VALUE_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire lldq_pkg::req_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output lldq_pkg::rsp_t      out_data
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NW = VALUE_BITS + 2 * AW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_PUSH = 3'd2;
  localparam logic [2:0] S_UNL1 = 3'd3;
  localparam logic [2:0] S_UNL2 = 3'd4;
  localparam logic [2:0] S_SWP1 = 3'd5;
  localparam logic [2:0] S_SWP2 = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  function automatic logic [VALUE_BITS-1:0] to_stored(logic signed [31:0] x);
    return VALUE_BITS'(x);
  endfunction

  function automatic logic [31:0] to_out(logic [VALUE_BITS-1:0] v);
    logic [63:0] x;
    x = 64'(signed'(v));
    return x[31:0];
  endfunction

  // Node memory: value, next link and prev link in one word, with a write mask per field.
  logic [NW-1:0]         mem [CAPACITY];
  logic [NW-1:0]         rd;
  logic [AW-1:0]         raddr;
  logic [AW-1:0]         waddr;
  logic                  we_v, we_n, we_p;
  logic [VALUE_BITS-1:0] wval;
  logic [AW-1:0]         wnext, wprev;

  always_ff @(posedge clk) begin
    if (we_v) mem[waddr][NW-1 -: VALUE_BITS] <= wval;
    if (we_n) mem[waddr][2*AW-1 -: AW] <= wnext;
    if (we_p) mem[waddr][AW-1:0] <= wprev;
    rd <= mem[raddr];
  end

  logic [CAPACITY-1:0]   used;
  logic [AW-1:0]         first, last, cur, sslot, tslot, lowfree, un_p, un_n;
  logic [CW-1:0]         count, k;
  logic [2:0]            state, op;
  logic [VALUE_BITS-1:0] va, vb, svalue, tvalue;
  logic                  phase;
  logic                  has_free;
  logic                  r_ok, r_full;
  logic [31:0]           r_value;
  logic                  in_push, in_walk, can_push, match, restart;

  logic [VALUE_BITS-1:0] rd_v;
  logic [AW-1:0]         rd_n, rd_p;
  assign rd_v = rd[NW-1 -: VALUE_BITS];
  assign rd_n = rd[2*AW-1 -: AW];
  assign rd_p = rd[AW-1:0];

  // Lowest free slot by a priority scan over the used map.
  always_comb begin
    lowfree = '0;
    has_free = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used[i]) begin
        lowfree = AW'(i);
        has_free = 1'b1;
      end
    end
  end

  // Decode of the incoming operation and of the node under the walk.
  assign in_push  = (in_data.opcode == lldq_pkg::OP_PUSH_FRONT) ||
                    (in_data.opcode == lldq_pkg::OP_PUSH_BACK);
  assign can_push = has_free && (count < CW'(CAPACITY));
  assign in_walk  = (in_data.opcode != lldq_pkg::OP_UNUSED) && !in_push && (count != '0) &&
                    ((in_data.opcode != lldq_pkg::OP_SWAP) || (count >= CW'(2)));
  assign match    = (rd_v == (phase ? vb : va));
  assign restart  = (op == lldq_pkg::OP_SWAP) && !phase && match;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign out_data = '{ok: r_ok, value_out: r_value, count_now: 7'(count),
                      refused_full: r_full};

  // Memory port control. Writes only happen outside the walk.
  always_comb begin
    raddr = rd_n;
    we_v = 1'b0; we_n = 1'b0; we_p = 1'b0;
    waddr = sslot; wval = va; wnext = '0; wprev = '0;
    case (state)
      S_IDLE: begin
        raddr = (in_data.opcode == lldq_pkg::OP_POP_BACK) ? last : first;
        if (in_valid && in_ready && in_push && can_push) begin
          we_v = 1'b1; we_n = 1'b1; we_p = 1'b1;
          waddr = lowfree;
          wval = to_stored(in_data.value_a);
          wnext = (in_data.opcode == lldq_pkg::OP_PUSH_FRONT && count != '0) ? first : '0;
          wprev = (in_data.opcode == lldq_pkg::OP_PUSH_BACK && count != '0) ? last : '0;
        end
      end
      S_WALK: begin
        if (restart) raddr = first;
      end
      S_PUSH: begin
        if (op == lldq_pkg::OP_PUSH_FRONT) begin
          we_p = 1'b1; waddr = un_n; wprev = sslot;
        end else begin
          we_n = 1'b1; waddr = un_p; wnext = sslot;
        end
      end
      S_UNL1: begin
        if (count != CW'(1) && sslot != first) begin
          we_n = 1'b1; waddr = un_p; wnext = un_n;
        end
      end
      S_UNL2: begin
        we_p = 1'b1; waddr = un_n; wprev = un_p;
      end
      S_SWP1: begin
        we_v = 1'b1; waddr = sslot; wval = tvalue;
      end
      S_SWP2: begin
        we_v = 1'b1; waddr = tslot; wval = svalue;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; used <= '0;
      first <= '0; last <= '0; count <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && in_ready) begin
          op <= in_data.opcode;
          va <= to_stored(in_data.value_a);
          vb <= to_stored(in_data.value_b);
          r_value <= '0;
          r_ok <= in_push && can_push;
          r_full <= in_push && !can_push;
          k <= '0; phase <= 1'b0;
          cur <= (in_data.opcode == lldq_pkg::OP_POP_BACK) ? last : first;
          un_n <= first; un_p <= last; sslot <= lowfree;
          if (in_push) begin
            if (can_push) begin
              used[lowfree] <= 1'b1;
              count <= count + CW'(1);
              if (count == '0) begin
                first <= lowfree; last <= lowfree; state <= S_OUT;
              end else if (in_data.opcode == lldq_pkg::OP_PUSH_FRONT) begin
                first <= lowfree; state <= S_PUSH;
              end else begin
                last <= lowfree; state <= S_PUSH;
              end
            end else begin
              state <= S_OUT;
            end
          end else if (in_walk) begin
            state <= S_WALK;
          end else begin
            state <= S_OUT;
          end
        end
        S_WALK: begin
          if (op == lldq_pkg::OP_POP_FRONT || op == lldq_pkg::OP_POP_BACK) begin
            r_value <= to_out(rd_v); r_ok <= 1'b1;
            sslot <= cur; un_p <= rd_p; un_n <= rd_n;
            state <= S_UNL1;
          end else if (match) begin
            if (op == lldq_pkg::OP_SEARCH) begin
              r_ok <= 1'b1; state <= S_OUT;
            end else if (op == lldq_pkg::OP_DELETE) begin
              r_ok <= 1'b1;
              sslot <= cur; un_p <= rd_p; un_n <= rd_n;
              state <= S_UNL1;
            end else if (!phase) begin
              // First value found: walk again from the front for the second.
              sslot <= cur; svalue <= rd_v; phase <= 1'b1;
              k <= '0; cur <= first;
            end else begin
              tslot <= cur; tvalue <= rd_v; r_ok <= 1'b1;
              state <= S_SWP1;
            end
          end else if ((k + CW'(1)) >= count) begin
            state <= S_OUT;
          end else begin
            k <= k + CW'(1); cur <= rd_n;
          end
        end
        S_PUSH: state <= S_OUT;
        S_UNL1: begin
          used[sslot] <= 1'b0;
          count <= count - CW'(1);
          if (count == CW'(1)) begin
            first <= '0; last <= '0; state <= S_OUT;
          end else begin
            if (sslot == first) first <= un_n;
            if (sslot == last) begin
              last <= un_p; state <= S_OUT;
            end else begin
              state <= S_UNL2;
            end
          end
        end
        S_UNL2: state <= S_OUT;
        S_SWP1: state <= S_SWP2;
        S_SWP2: state <= S_OUT;
        S_OUT: begin
          out_valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY)) else $error("count over capacity");
  a_used_count: assert property (@(posedge clk) disable iff (rst)
    $countones(used) == int'(count)) else $error("used map disagrees with count");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while waiting");
`endif
endmodule
`default_nettype wire
